>>> hdl/nslf_pkg.sv
// ----------------------------------------------------------------------------
// NMEA line filter package
// Shared codes, character constants and sentence prefix tables.
// ----------------------------------------------------------------------------
package nslf_pkg;

    // Input word opcodes (travel in s_axis_tuser)
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes (travel in m_axis_tuser)
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_LINE_END = 3'd1;
    localparam logic [2:0] ST_FRAMING  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;

    // Sentence kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_VTG  = 2'd2;
    localparam logic [1:0] KIND_HMC  = 2'd3;

    // Characters
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_RESET = 8'd65;

    // Lines are dropped this many entries short of the line store depth
    localparam int OVERFLOW_MARGIN = 10;

    localparam int COMMA_W = 7;
    localparam logic [COMMA_W-1:0] COMMA_MAX = 7'd127;

    // Prefix length per sentence (index 0 GGA, 1 VTG, 2 HMC)
    function automatic logic [2:0] pat_len(input logic [1:0] idx);
        logic [2:0] len;
        case (idx)
            2'd0:    len = 3'd6;
            2'd1:    len = 3'd6;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

    // Expected comma count per sentence
    function automatic logic [COMMA_W-1:0] pat_commas(input logic [1:0] idx);
        logic [COMMA_W-1:0] cnt;
        case (idx)
            2'd0:    cnt = 7'd14;
            2'd1:    cnt = 7'd9;
            default: cnt = 7'd3;
        endcase
        return cnt;
    endfunction

    // Prefix character at a position; positions past the length are unused
    function automatic logic [7:0] pat_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            2'd0: begin
                case (pos)
                    3'd0:    ch = "$";
                    3'd1:    ch = "G";
                    3'd2:    ch = "P";
                    3'd3:    ch = "G";
                    3'd4:    ch = "G";
                    3'd5:    ch = "A";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0:    ch = "$";
                    3'd1:    ch = "G";
                    3'd2:    ch = "P";
                    3'd3:    ch = "V";
                    3'd4:    ch = "T";
                    3'd5:    ch = "G";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    ch = "$";
                    3'd1:    ch = "H";
                    3'd2:    ch = "M";
                    3'd3:    ch = "C";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/nmea_sentence_line_filter_core.sv
// ----------------------------------------------------------------------------
// NMEA sentence line filter core
// Frames received bytes into CR LF lines, tracks sentence prefixes and
// comma counts, and gates complete GGA/VTG/HMC lines with pending flags.
// ----------------------------------------------------------------------------
// The result of an accepted input word is registered and shows the cycle after.
// Throughput: one word per cycle while results are taken; the line state is
// updated by prefix compare and comma count logic ahead of the result register.
// The result register decouples the sides: a new word is taken while the
// previous result waits, as long as the result is being taken that cycle.
// Reset (aresetn low, synchronous): line tracking restarts, flags clear.
module nmea_sentence_line_filter_core
    import nslf_pkg::*;
#(
    parameter int LINE_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_byte, [9:8] release_kind, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [0] opcode
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] echo_byte, [14:8] byte_position, [16:15] sentence_kind,
    // [17] accepted, [18] gga_pending, [19] vtg_pending, [20] hmc_pending,
    // [23:21] zero
    output logic [23:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser
);

    localparam int POS_W     = $clog2(LINE_DEPTH);
    localparam int POS_LIMIT = LINE_DEPTH - OVERFLOW_MARGIN;

    // Line state
    logic [7:0]         prev_byte_reg, prev_byte_next;
    logic [POS_W-1:0]   line_pos_reg, line_pos_next;
    logic [COMMA_W-1:0] comma_cnt_reg, comma_cnt_next;
    logic [2:0]         prefix_match_reg, prefix_match_next;
    logic [2:0]         pending_reg, pending_next;

    // Result register
    logic        m_valid_reg;
    logic [23:0] m_data_reg, m_data_next;
    logic [2:0]  m_user_reg, m_user_next;

    logic       s_fire;
    logic       opcode;
    logic [7:0] rx_byte;
    logic [1:0] release_kind;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign opcode        = s_axis_tuser[0];
    assign rx_byte       = s_axis_tdata[7:0];
    assign release_kind  = s_axis_tdata[9:8];

    // Decode one word into next line state and its result
    always_comb begin
        logic [2:0] status;
        logic [1:0] kind;
        logic       acc;
        logic [7:0] echo;
        logic [6:0] pos_out;
        logic [2:0] hits;
        logic       restart;
        logic [1:0] kidx;
        logic [31:0] pos_ext;

        prev_byte_next    = prev_byte_reg;
        line_pos_next     = line_pos_reg;
        comma_cnt_next    = comma_cnt_reg;
        prefix_match_next = prefix_match_reg;
        pending_next      = pending_reg;
        status  = ST_STORED;
        kind    = KIND_NONE;
        acc     = 1'b0;
        echo    = 8'h00;
        pos_out = 7'd0;
        hits    = 3'b000;
        restart = 1'b0;
        kidx    = 2'd0;
        pos_ext = 32'(line_pos_reg);

        if (opcode == OP_RELEASE) begin
            // Clear one pending flag; kind zero leaves flags alone
            status = ST_RELEASED;
            kind   = release_kind;
            case (release_kind)
                KIND_GGA: pending_next[0] = 1'b0;
                KIND_VTG: pending_next[1] = 1'b0;
                KIND_HMC: pending_next[2] = 1'b0;
                default:  pending_next    = pending_reg;
            endcase
        end else begin
            prev_byte_next = rx_byte;
            echo           = rx_byte;
            pos_out        = pos_ext[6:0];

            if ((prev_byte_reg == CH_CR && rx_byte != CH_LF) ||
                (rx_byte == CH_LF && prev_byte_reg != CH_CR)) begin
                // Bad CR/LF pairing: drop the line
                status  = ST_FRAMING;
                restart = 1'b1;
            end else if (line_pos_reg >= POS_W'(POS_LIMIT)) begin
                // Line too long for the store: drop it
                status  = ST_OVERFLOW;
                restart = 1'b1;
            end else if (prev_byte_reg == CH_CR && rx_byte == CH_LF) begin
                // Good line end: pick the sentence, last match wins
                status = ST_LINE_END;
                for (int k = 0; k < 3; k++) begin
                    hits[k] = prefix_match_reg[k] &&
                              (pos_ext >= 32'(pat_len(2'(k))));
                    if (hits[k]) begin
                        kind = 2'(k + 1);
                    end
                end
                if (kind != KIND_NONE) begin
                    kidx = kind - 2'd1;
                    if (comma_cnt_reg == pat_commas(kidx) && !pending_reg[kidx]) begin
                        pending_next[kidx] = 1'b1;
                        acc                = 1'b1;
                    end
                end
                restart = 1'b1;
            end else begin
                // Store the byte: narrow the prefix set and count commas
                for (int k = 0; k < 3; k++) begin
                    if (pos_ext < 32'(pat_len(2'(k))) &&
                        rx_byte != pat_char(2'(k), line_pos_reg[2:0])) begin
                        prefix_match_next[k] = 1'b0;
                    end
                end
                if (rx_byte == CH_COMMA && comma_cnt_reg != COMMA_MAX) begin
                    comma_cnt_next = comma_cnt_reg + COMMA_W'(1);
                end
                line_pos_next = line_pos_reg + POS_W'(1);
            end

            if (restart) begin
                line_pos_next     = '0;
                comma_cnt_next    = '0;
                prefix_match_next = 3'b111;
            end
        end

        m_data_next = {3'b000, pending_next[2], pending_next[1], pending_next[0],
                       acc, kind, pos_out, echo};
        m_user_next = status;
    end

    // Advance line state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg    <= CH_RESET;
            line_pos_reg     <= '0;
            comma_cnt_reg    <= '0;
            prefix_match_reg <= 3'b111;
            pending_reg      <= 3'b000;
        end else if (s_fire) begin
            prev_byte_reg    <= prev_byte_next;
            line_pos_reg     <= line_pos_next;
            comma_cnt_reg    <= comma_cnt_next;
            prefix_match_reg <= prefix_match_next;
            pending_reg      <= pending_next;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

>>> hdl/nslf_checker.sv
// ----------------------------------------------------------------------------
// NMEA line filter port checker
// Watches the stream ports of the core for result consistency over time.
// ----------------------------------------------------------------------------
module nslf_checker
    import nslf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Every accepted word yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    // An accepted line shows its own flag set and the line end status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[17] |->
            m_axis_tuser == ST_LINE_END &&
            ((m_axis_tdata[16:15] == KIND_GGA && m_axis_tdata[18]) ||
             (m_axis_tdata[16:15] == KIND_VTG && m_axis_tdata[19]) ||
             (m_axis_tdata[16:15] == KIND_HMC && m_axis_tdata[20])))
        else $error("accepted line without matching pending flag");

    // A GGA release shows the GGA flag cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_RELEASE &&
        s_axis_tdata[9:8] == KIND_GGA |=> !m_axis_tdata[18])
        else $error("GGA flag still set after release");

    // Stored bytes carry no sentence kind and no accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_STORED |->
            m_axis_tdata[16:15] == KIND_NONE && !m_axis_tdata[17])
        else $error("stored byte carries sentence result");

endmodule

bind nmea_sentence_line_filter_core nslf_checker u_nslf_checker (.*);

>>> tb/tb_nslf_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA line filter scoreboard
// Tracks line framing, prefix matching, comma counts and pending flags
// for every accepted input word, and checks each result word against the
// oldest prediction.
// ----------------------------------------------------------------------------
package tb_nslf_scoreboard_pkg;

    import nslf_pkg::*;

    // One predicted result word
    typedef struct {
        logic [7:0] echo;
        logic [6:0] pos;
        logic [2:0] status;
        logic [1:0] kind;
        logic       acc;
        logic [2:0] flags;
    } line_echo_t;

    class nmea_scoreboard;

        int          line_depth;
        logic [7:0]  prev_byte;
        int          line_pos;
        int          commas;
        logic [2:0]  prefix_ok;
        logic [2:0]  flags;
        line_echo_t  echo_q[$];
        int unsigned errors;

        string       prefixes[3] = '{"$GPGGA", "$GPVTG", "$HMC"};
        int          need_commas[3] = '{14, 9, 3};

        function new(int depth);
            line_depth = depth;
            prev_byte  = CH_RESET;
            flags      = 3'b000;
            errors     = 0;
            restart_line();
        endfunction

        function void restart_line();
            line_pos  = 0;
            commas    = 0;
            prefix_ok = 3'b111;
        endfunction

        function int outstanding();
            return echo_q.size();
        endfunction

        // Advance the line state for one accepted word and queue its result
        function void note_word(logic op, logic [7:0] b, logic [1:0] rk);
            line_echo_t r;
            logic [7:0] prev;
            r.echo   = 8'd0;
            r.pos    = 7'd0;
            r.status = ST_STORED;
            r.kind   = KIND_NONE;
            r.acc    = 1'b0;
            if (op == OP_RELEASE) begin
                if (rk != KIND_NONE) flags[rk - 1] = 1'b0;
                r.status = ST_RELEASED;
                r.kind   = rk;
            end else begin
                prev      = prev_byte;
                prev_byte = b;
                r.echo    = b;
                r.pos     = line_pos[6:0];
                if ((prev == CH_CR && b != CH_LF) || (b == CH_LF && prev != CH_CR)) begin
                    r.status = ST_FRAMING;
                    restart_line();
                end else if (line_pos >= line_depth - OVERFLOW_MARGIN) begin
                    r.status = ST_OVERFLOW;
                    restart_line();
                end else if (prev == CH_CR) begin
                    // CR LF: the last fully seen prefix wins
                    r.status = ST_LINE_END;
                    for (int k = 0; k < 3; k++) begin
                        if (prefix_ok[k] && line_pos >= prefixes[k].len())
                            r.kind = 2'(k + 1);
                    end
                    if (r.kind != KIND_NONE) begin
                        if (commas == need_commas[r.kind - 1] && !flags[r.kind - 1]) begin
                            flags[r.kind - 1] = 1'b1;
                            r.acc = 1'b1;
                        end
                    end
                    restart_line();
                end else begin
                    // Store the byte: drop prefixes it breaks, count commas
                    for (int k = 0; k < 3; k++) begin
                        if (line_pos < prefixes[k].len() && b != prefixes[k][line_pos])
                            prefix_ok[k] = 1'b0;
                    end
                    if (b == CH_COMMA && commas < int'(COMMA_MAX)) commas++;
                    line_pos++;
                end
            end
            r.flags = flags;
            echo_q.push_back(r);
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one result word with the oldest prediction
        function void check_word(logic [23:0] data, logic [2:0] user);
            line_echo_t r;
            if (echo_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual data %h status %0d",
                         $time, data, user);
                return;
            end
            r = echo_q.pop_front();
            check_field("echo_byte", int'(r.echo), int'(data[7:0]));
            check_field("byte_position", int'(r.pos), int'(data[14:8]));
            check_field("sentence_kind", int'(r.kind), int'(data[16:15]));
            check_field("accepted", int'(r.acc), int'(data[17]));
            check_field("gga_pending", int'(r.flags[0]), int'(data[18]));
            check_field("vtg_pending", int'(r.flags[1]), int'(data[19]));
            check_field("hmc_pending", int'(r.flags[2]), int'(data[20]));
            check_field("status", int'(r.status), int'(user));
        endfunction

    endclass

endpackage

>>> tb/tb_nmea_sentence_line_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence line filter core testbench
// Feeds directed lines and then random sentences, releases, noise, broken
// and overlong lines through the stream input with bursty timing, stalls
// the result side on its own pattern including one long hold-off, and
// checks every result word in order against the scoreboard.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_line_filter_core;

    import nslf_pkg::*;
    import tb_nslf_scoreboard_pkg::*;

    localparam int DEPTH       = 128;
    localparam int N_WORDS     = 1180;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic [0:0]  s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    nmea_scoreboard sb = new(DEPTH);

    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_cnt  = 0;

    nmea_sentence_line_filter_core #(
        .LINE_DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check every result word taken by the receiver
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: short random stretch, one long hold-off, then mixed patterns
    initial begin
        int n;
        int mode;
        logic [7:0] mask;
        do @(posedge aclk); while (!aresetn);
        repeat (150) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
            @(posedge aclk);
        end
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 2);
            n    = $urandom_range(10, 80);
            mask = 8'($urandom_range(0, 255));
            for (int i = 0; i < n; i++) begin
                case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= mask[i % 8];
                    end
                    default: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic [1:0] rand_kind();
        return 2'($urandom_range(0, 3));
    endfunction

    // Any byte that is not CR, LF or comma
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF || c == CH_COMMA);
        return c;
    endfunction

    // Offer one word, hold it until taken, then idle at burst ends
    task automatic send_word(input logic op, input logic [7:0] b, input logic [1:0] rk);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, rk, b};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_word(op, b, rk);
        words_sent++;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_word(OP_BYTE, t[i], rand_kind());
    endtask

    task automatic send_line_end();
        send_word(OP_BYTE, CH_CR, rand_kind());
        send_word(OP_BYTE, CH_LF, rand_kind());
    endtask

    // Sentence with random fields; comma count sometimes off, rare stray CR/LF
    task automatic send_sentence(input int kind);
        string head;
        int commas;
        int n;
        case (kind)
            0: begin
                head = "$GPGGA";
                commas = 14;
            end
            1: begin
                head = "$GPVTG";
                commas = 9;
            end
            2: begin
                head = "$HMC";
                commas = 3;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       head = "$GPRMC";
                    1:       head = "$GPGGB";
                    default: head = "$HM";
                endcase
                commas = 3;
            end
        endcase
        if ($urandom_range(0, 3) == 0) commas = commas + int'($urandom_range(0, 4)) - 2;
        send_text(head);
        for (int f = 0; f < commas; f++) begin
            n = $urandom_range(0, 4);
            repeat (n) send_word(OP_BYTE, body_char(), rand_kind());
            if ($urandom_range(0, 39) == 0)
                send_word(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, rand_kind());
            send_word(OP_BYTE, CH_COMMA, rand_kind());
        end
        if ($urandom_range(0, 1)) send_text("*4F");
        send_line_end();
    endtask

    initial begin
        int sel;
        int n;
        string head;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: accepted line, busy flag, every release kind
        send_text("$HMC,,,");
        send_line_end();
        send_text("$HMC,,,");
        send_line_end();
        send_word(OP_RELEASE, 8'hFF, KIND_HMC);
        send_word(OP_RELEASE, 8'h00, KIND_NONE);
        send_word(OP_RELEASE, 8'hA5, KIND_GGA);
        send_word(OP_RELEASE, 8'h5A, KIND_VTG);
        // Lone LF, extreme bytes, CR followed by a non-LF byte
        send_word(OP_BYTE, CH_LF, KIND_NONE);
        send_word(OP_BYTE, 8'hFF, 2'd3);
        send_word(OP_BYTE, CH_CR, KIND_NONE);
        send_word(OP_BYTE, 8'h00, 2'd3);
        // Line shorter than any prefix
        send_text("$");
        send_line_end();

        // Random traffic, mostly well-formed sentences
        while (words_sent < N_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                send_sentence($urandom_range(0, 3));
            end else if (sel < 70) begin
                send_word(OP_RELEASE, 8'($urandom_range(0, 255)), rand_kind());
            end else if (sel < 80) begin
                n = $urandom_range(1, 8);
                repeat (n) send_word(OP_BYTE, 8'($urandom_range(0, 255)), rand_kind());
                send_line_end();
            end else if (sel < 88) begin
                send_text("$GP");
                if ($urandom_range(0, 1)) begin
                    send_word(OP_BYTE, CH_CR, rand_kind());
                    send_word(OP_BYTE, body_char(), rand_kind());
                end else begin
                    send_word(OP_BYTE, CH_LF, rand_kind());
                end
            end else if (sel < 92) begin
                n = $urandom_range(DEPTH - OVERFLOW_MARGIN, DEPTH - 3);
                repeat (n) send_word(OP_BYTE, body_char(), rand_kind());
                send_line_end();
            end else begin
                case ($urandom_range(0, 2))
                    0:       head = "$GPGGA";
                    1:       head = "$GPVTG";
                    default: head = "$HMC";
                endcase
                send_text(head.substr(0, $urandom_range(0, head.len() - 2)));
                send_line_end();
            end
        end
        if (burst_left != 0) s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.outstanding() != 0)
            $display("%0t: %0d result words never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
